// ===== sv/ept_pkg.sv =====
// Shared types and constants of the event parameter table.
package ept_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SAT_W = (CNT_W > 7) ? CNT_W : 7;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [3:0] {
    REQ_GET       = 4'd0,
    REQ_SET       = 4'd1,
    REQ_MOVE      = 4'd2,
    REQ_REMOVE    = 4'd3,
    REQ_PREV_ANY  = 4'd4,
    REQ_PREV_IDX  = 4'd5,
    REQ_NEXT      = 4'd6,
    REQ_COUNT     = 4'd7,
    REQ_START     = 4'd8,
    REQ_CLEAR     = 4'd9
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_ENABLE_INDEX  = 1'b0,
    CFG_ENABLED_VALUE = 1'b1
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [30:0]        pos;
    logic signed [15:0] idx;
    logic [31:0]        val;
  } slot_t;

  typedef struct packed {
    logic  load;
    logic  scan_en;
    addr_t scan_addr;
    logic  commit;
  } ctrl_cmd_t;

endpackage

// ===== sv/event_parameter_table.sv =====
// Top level of the event parameter table.
// A request word is accepted only in the idle state; no new request is taken until the
// last result is committed. The single-port slot memory scan reads one slot per cycle over all
// 64 slots, then a drain and a commit state follow; the commit waits while a held result is stalled.
// Reset clears the slot valid bits, the entry count and the handshake state at once;
// the configuration registers return to index 0 and value word 0x3F800000.
module event_parameter_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         req_type_i,
  input  logic [30:0]        position_i,
  input  logic signed [15:0] param_index_i,
  input  logic [31:0]        value_bits_i,
  input  logic [30:0]        new_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [31:0]        read_value_o,
  output logic [30:0]        result_position_o,
  output logic [6:0]         entry_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  ept_pkg::ctrl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  ept_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ept_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .req_type_i        (req_type_i),
    .position_i        (position_i),
    .param_index_i     (param_index_i),
    .value_bits_i      (value_bits_i),
    .new_position_i    (new_position_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .status_o          (status_o),
    .read_value_o      (read_value_o),
    .result_position_o (result_position_o),
    .entry_count_o     (entry_count_o)
  );

endmodule

// ===== sv/ept_ctrl.sv =====
// Sequencing controller of the event parameter table.
module ept_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ept_pkg::ctrl_cmd_t cmd_o
);

  ept_pkg::state_e state_q, state_d;
  ept_pkg::addr_t  scan_addr_q, scan_addr_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            scan_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_last = (scan_addr_q == ept_pkg::ADDR_W'(ept_pkg::TABLE_DEPTH - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ept_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ept_pkg::ST_SCAN;
      end
      ept_pkg::ST_SCAN: begin
        if (scan_last) state_d = ept_pkg::ST_DRAIN;
      end
      ept_pkg::ST_DRAIN: begin
        state_d = ept_pkg::ST_COMMIT;
      end
      ept_pkg::ST_COMMIT: begin
        if (out_free) state_d = ept_pkg::ST_IDLE;
      end
      default: state_d = ept_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load      = (state_q == ept_pkg::ST_IDLE) && in_valid_i;
    cmd_o.scan_en   = (state_q == ept_pkg::ST_SCAN);
    cmd_o.scan_addr = scan_addr_q;
    cmd_o.commit    = (state_q == ept_pkg::ST_COMMIT) && out_free;
    in_stall_o      = (state_q != ept_pkg::ST_IDLE);
    out_valid_o     = out_valid_q;
  end

  always_comb begin
    scan_addr_d = scan_addr_q;
    if (cmd_o.load) begin
      scan_addr_d = '0;
    end else if (cmd_o.scan_en) begin
      scan_addr_d = scan_addr_q + ept_pkg::ADDR_W'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ept_pkg::ST_IDLE;
      scan_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_addr_q <= scan_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while still held");
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ept_pkg::ST_SCAN && scan_addr_q == '0))
    else $error("scan did not start from the first slot");
  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.commit))
    else $error("result raised without a commit");
`endif

endmodule

// ===== sv/ept_datapath.sv =====
// Slot memory, scan evaluation and result register of the event parameter table.
module ept_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ept_pkg::ctrl_cmd_t cmd_i,
  input  logic [3:0]         req_type_i,
  input  logic [30:0]        position_i,
  input  logic signed [15:0] param_index_i,
  input  logic [31:0]        value_bits_i,
  input  logic [30:0]        new_position_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic [1:0]         status_o,
  output logic [31:0]        read_value_o,
  output logic [30:0]        result_position_o,
  output logic [6:0]         entry_count_o
);

  ept_pkg::slot_t slot_mem [ept_pkg::TABLE_DEPTH];
  ept_pkg::slot_t rd_data_q;

  logic [ept_pkg::TABLE_DEPTH-1:0] valid_q, valid_d;
  ept_pkg::cnt_t count_q, count_d;

  logic signed [15:0] en_idx_q;
  logic [31:0]        en_val_q;

  ept_pkg::req_e      req_q;
  logic [30:0]        pos_q;
  logic signed [15:0] idx_q;
  logic [31:0]        val_q;
  logic [30:0]        npos_q;

  logic           eval_q;
  ept_pkg::addr_t eval_slot_q;

  logic           s_found_q, d_found_q, free_found_q;
  ept_pkg::addr_t s_slot_q, d_slot_q, free_slot_q;
  logic [31:0]    s_val_q;
  logic [30:0]    prev_q, next_q, start_q;
  logic           next_have_q, start_have_q;

  logic ev_valid, hit_s, hit_d, hit_free, hit_prev, hit_next, hit_start;

  logic             wr_en;
  ept_pkg::addr_t   wr_addr;
  ept_pkg::slot_t   wr_data;
  logic             cnt_inc, cnt_dec;
  ept_pkg::status_e status_d;
  logic [31:0]      rval_d;
  logic [30:0]      rpos_d;
  logic [ept_pkg::SAT_W-1:0] count_ext;

  logic [1:0]  status_q;
  logic [31:0] rval_q;
  logic [30:0] rpos_q;
  logic [6:0]  entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_idx_q <= '0;
      en_val_q <= 32'h3F80_0000;
    end else if (cfg_we_i) begin
      unique case (ept_pkg::cfg_e'(cfg_index_i))
        ept_pkg::CFG_ENABLE_INDEX:  en_idx_q <= cfg_data_i[15:0];
        ept_pkg::CFG_ENABLED_VALUE: en_val_q <= cfg_data_i;
        default: en_val_q <= en_val_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= ept_pkg::req_e'(req_type_i);
      pos_q  <= position_i;
      idx_q  <= param_index_i;
      val_q  <= value_bits_i;
      npos_q <= new_position_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && cmd_i.commit) slot_mem[wr_addr] <= wr_data;
    if (cmd_i.scan_en) rd_data_q <= slot_mem[cmd_i.scan_addr];
  end

  always_comb begin
    ev_valid  = eval_q && valid_q[eval_slot_q];
    hit_s     = ev_valid && rd_data_q.pos == pos_q && rd_data_q.idx == idx_q;
    hit_d     = ev_valid && rd_data_q.pos == npos_q && rd_data_q.idx == idx_q;
    hit_free  = eval_q && !valid_q[eval_slot_q] && !free_found_q;
    hit_prev  = ev_valid && (req_q != ept_pkg::REQ_PREV_IDX || rd_data_q.idx == idx_q) &&
                rd_data_q.pos < pos_q && rd_data_q.pos > prev_q;
    hit_next  = ev_valid && rd_data_q.pos > pos_q &&
                (!next_have_q || rd_data_q.pos < next_q);
    hit_start = ev_valid && rd_data_q.idx == en_idx_q && rd_data_q.val == en_val_q &&
                (!start_have_q || rd_data_q.pos < start_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q       <= 1'b0;
      s_found_q    <= 1'b0;
      d_found_q    <= 1'b0;
      free_found_q <= 1'b0;
      next_have_q  <= 1'b0;
      start_have_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.scan_en;
      if (cmd_i.load) begin
        s_found_q    <= 1'b0;
        d_found_q    <= 1'b0;
        free_found_q <= 1'b0;
        next_have_q  <= 1'b0;
        start_have_q <= 1'b0;
      end else begin
        if (hit_s) s_found_q <= 1'b1;
        if (hit_d) d_found_q <= 1'b1;
        if (hit_free) free_found_q <= 1'b1;
        if (hit_next) next_have_q <= 1'b1;
        if (hit_start) start_have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eval_slot_q <= cmd_i.scan_addr;
    if (cmd_i.load) begin
      prev_q  <= '0;
      next_q  <= '0;
      start_q <= '0;
    end else begin
      if (hit_s) begin
        s_slot_q <= eval_slot_q;
        s_val_q  <= rd_data_q.val;
      end
      if (hit_d) d_slot_q <= eval_slot_q;
      if (hit_free) free_slot_q <= eval_slot_q;
      if (hit_prev) prev_q <= rd_data_q.pos;
      if (hit_next) next_q <= rd_data_q.pos;
      if (hit_start) start_q <= rd_data_q.pos;
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = s_slot_q;
    wr_data  = '{pos: pos_q, idx: idx_q, val: val_q};
    valid_d  = valid_q;
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    status_d = ept_pkg::STAT_OK;
    rval_d   = '0;
    rpos_d   = '0;
    unique case (req_q)
      ept_pkg::REQ_GET: begin
        if (s_found_q) rval_d = s_val_q;
        else status_d = ept_pkg::STAT_NOT_FOUND;
      end
      ept_pkg::REQ_SET: begin
        if (s_found_q) begin
          wr_en = 1'b1;
        end else if (free_found_q) begin
          wr_en   = 1'b1;
          wr_addr = free_slot_q;
          valid_d[free_slot_q] = 1'b1;
          cnt_inc = !idx_q[15];
        end else begin
          status_d = ept_pkg::STAT_FULL;
        end
      end
      ept_pkg::REQ_MOVE: begin
        if (!s_found_q) begin
          status_d = ept_pkg::STAT_NOT_FOUND;
        end else begin
          wr_en   = 1'b1;
          wr_data = '{pos: npos_q, idx: idx_q, val: s_val_q};
          if (d_found_q && d_slot_q != s_slot_q) begin
            wr_addr = d_slot_q;
            valid_d[s_slot_q] = 1'b0;
            cnt_dec = !idx_q[15];
          end
        end
      end
      ept_pkg::REQ_REMOVE: begin
        if (s_found_q) begin
          valid_d[s_slot_q] = 1'b0;
          cnt_dec = !idx_q[15];
        end else begin
          status_d = ept_pkg::STAT_NOT_FOUND;
        end
      end
      ept_pkg::REQ_PREV_ANY,
      ept_pkg::REQ_PREV_IDX: rpos_d = prev_q;
      ept_pkg::REQ_NEXT:     rpos_d = next_q;
      ept_pkg::REQ_START:    rpos_d = start_q;
      ept_pkg::REQ_CLEAR:    valid_d = '0;
      default: rpos_d = '0;
    endcase
    if (req_q == ept_pkg::REQ_CLEAR) begin
      count_d = '0;
    end else begin
      count_d = count_q + ept_pkg::CNT_W'(cnt_inc) - ept_pkg::CNT_W'(cnt_dec);
    end
    count_ext = ept_pkg::SAT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      rval_q   <= rval_d;
      rpos_q   <= rpos_d;
      entry_q  <= (count_ext > ept_pkg::SAT_W'(127)) ? 7'd127 : count_ext[6:0];
    end
  end

  assign status_o          = status_q;
  assign read_value_o      = rval_q;
  assign result_position_o = rpos_q;
  assign entry_count_o     = entry_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ept_pkg::CNT_W'($countones(valid_q)))
    else $error("entry count exceeds occupied slots");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && req_q == ept_pkg::REQ_CLEAR) |=> (valid_q == '0 && count_q == '0))
    else $error("clear left entries behind");
  a_full_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && status_d == ept_pkg::STAT_FULL) |-> (&valid_q))
    else $error("table reported full with a free slot");
`endif

endmodule
